### src/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// widths and payload types shared by the quaternion vector rotation core
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QW  = 16;                         // quaternion part width
    localparam int VW  = 16;                         // vector part width
    localparam int PW  = 2 * QW;                     // quaternion square
    localparam int CPW = QW + VW;                    // quaternion times vector
    localparam int NW  = 2 * QW + 1;                 // norm, unsigned
    localparam int SW  = (2 * QW + 2 > QW + VW + 2) ? 2 * QW + 2 : QW + VW + 2;
    localparam int TW  = SW + ((VW > QW + 1) ? VW : QW + 1);
    localparam int MW  = TW + 2;                     // numerator and remainder
    localparam int QB  = VW + 1;                     // quotient bits

    typedef struct packed {
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [QW-1:0] quat_w;
        logic signed [VW-1:0] vec_x;
        logic signed [VW-1:0] vec_y;
        logic signed [VW-1:0] vec_z;
    } t_qvr_in;

    typedef struct packed {
        logic signed [VW-1:0] rot_x;
        logic signed [VW-1:0] rot_y;
        logic signed [VW-1:0] rot_z;
        logic                 zero_quat;
        logic                 clipped;
    } t_qvr_out;

    typedef struct packed {
        logic [2:0][MW-1:0] rem;
        logic [MW-1:0]      dsh;
        logic [2:0][QB-1:0] quo;
        logic [2:0]         neg;
        logic               zero;
    } t_div_bus;

endpackage

### src/qvr_front.sv
// ----------------------------------------------------------------------------
// qvr_front
// five register stages: products, sums, weighted terms, numerators, rounding
// ----------------------------------------------------------------------------
module qvr_front import qvr_pkg::*; (
    input  logic          i_clk,
    input  logic [4:0]    i_en,
    input  t_qvr_in       i_data,
    output t_div_bus      o_bus
);

    // stage 1
    logic signed [QW-1:0]  r1_q [3];
    logic signed [QW-1:0]  r1_w;
    logic signed [VW-1:0]  r1_v [3];
    logic signed [PW-1:0]  r1_sq [3];
    logic signed [PW-1:0]  r1_ww;
    logic signed [CPW-1:0] r1_dot [3];
    logic signed [CPW-1:0] r1_cp [3];
    logic signed [CPW-1:0] r1_cm [3];
    // stage 2
    logic signed [QW-1:0]  r2_q [3];
    logic signed [QW-1:0]  r2_w;
    logic signed [VW-1:0]  r2_v [3];
    logic [NW-1:0]         r2_n;
    logic signed [SW-1:0]  r2_a;
    logic signed [SW-1:0]  r2_d;
    logic signed [SW-1:0]  r2_c [3];
    // stage 3
    logic [NW-1:0]         r3_n;
    logic signed [TW-1:0]  r3_av [3];
    logic signed [TW-1:0]  r3_dq [3];
    logic signed [TW-1:0]  r3_cw [3];
    // stage 4
    logic [NW-1:0]         r4_n;
    logic signed [MW-1:0]  r4_num [3];
    // stage 5
    t_div_bus              r5_bus;

    logic signed [QW-1:0]  s_q [3];
    logic signed [VW-1:0]  s_v [3];

    assign s_q[0] = i_data.quat_x;
    assign s_q[1] = i_data.quat_y;
    assign s_q[2] = i_data.quat_z;
    assign s_v[0] = i_data.vec_x;
    assign s_v[1] = i_data.vec_y;
    assign s_v[2] = i_data.vec_z;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_w  <= i_data.quat_w;
            r1_ww <= PW'(i_data.quat_w * i_data.quat_w);
            for (int i = 0; i < 3; i++) begin
                r1_q[i]   <= s_q[i];
                r1_v[i]   <= s_v[i];
                r1_sq[i]  <= PW'(s_q[i] * s_q[i]);
                r1_dot[i] <= CPW'(s_q[i] * s_v[i]);
                // cross product halves: u(i+1)*v(i+2) and u(i+2)*v(i+1)
                r1_cp[i]  <= CPW'(s_q[(i+1)%3] * s_v[(i+2)%3]);
                r1_cm[i]  <= CPW'(s_q[(i+2)%3] * s_v[(i+1)%3]);
            end
        end
        if (i_en[1]) begin
            r2_w <= r1_w;
            r2_n <= NW'($unsigned(r1_ww)) + NW'($unsigned(r1_sq[0]))
                  + NW'($unsigned(r1_sq[1])) + NW'($unsigned(r1_sq[2]));
            r2_a <= SW'(r1_ww) - SW'(r1_sq[0]) - SW'(r1_sq[1]) - SW'(r1_sq[2]);
            r2_d <= SW'(r1_dot[0]) + SW'(r1_dot[1]) + SW'(r1_dot[2]);
            for (int i = 0; i < 3; i++) begin
                r2_q[i] <= r1_q[i];
                r2_v[i] <= r1_v[i];
                r2_c[i] <= SW'(r1_cp[i]) - SW'(r1_cm[i]);
            end
        end
        if (i_en[2]) begin
            r3_n <= r2_n;
            for (int i = 0; i < 3; i++) begin
                r3_av[i] <= TW'(r2_a * r2_v[i]);
                r3_dq[i] <= TW'(r2_d * $signed({r2_q[i], 1'b0}));
                r3_cw[i] <= TW'(r2_c[i] * $signed({r2_w, 1'b0}));
            end
        end
        if (i_en[3]) begin
            r4_n <= r3_n;
            for (int i = 0; i < 3; i++) begin
                r4_num[i] <= MW'(r3_av[i]) + MW'(r3_dq[i]) + MW'(r3_cw[i]);
            end
        end
        if (i_en[4]) begin
            // magnitude plus half the norm, ready for a round-to-nearest divide
            r5_bus.dsh  <= MW'(r4_n) << (QB - 1);
            r5_bus.zero <= (r4_n == '0);
            for (int i = 0; i < 3; i++) begin
                r5_bus.neg[i] <= r4_num[i][MW-1];
                r5_bus.quo[i] <= '0;
                r5_bus.rem[i] <= (r4_num[i][MW-1] ? MW'(-r4_num[i]) : MW'(r4_num[i]))
                               + MW'(r4_n >> 1);
            end
        end
    end

    assign o_bus = r5_bus;

endmodule

### src/qvr_div_step.sv
// ----------------------------------------------------------------------------
// qvr_div_step
// one restoring divide step for the three components, one quotient bit
// ----------------------------------------------------------------------------
module qvr_div_step import qvr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_div_bus i_bus,
    output t_div_bus o_bus
);

    t_div_bus r_bus;
    t_div_bus n_bus;

    always_comb begin
        n_bus     = i_bus;
        n_bus.dsh = i_bus.dsh >> 1;
        for (int i = 0; i < 3; i++) begin
            if (i_bus.rem[i] >= i_bus.dsh) begin
                n_bus.rem[i] = i_bus.rem[i] - i_bus.dsh;
                n_bus.quo[i] = {i_bus.quo[i][QB-2:0], 1'b1};
            end else begin
                n_bus.quo[i] = {i_bus.quo[i][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

### src/qvr_sat.sv
// ----------------------------------------------------------------------------
// qvr_sat
// output register: saturation, sign restore and zero quaternion handling
// ----------------------------------------------------------------------------
module qvr_sat import qvr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_div_bus i_bus,
    output t_qvr_out o_data
);

    localparam logic [QB-1:0] LimPos = (QB'(1) << (VW - 1)) - QB'(1);
    localparam logic [QB-1:0] LimNeg = QB'(1) << (VW - 1);

    t_qvr_out          r_data;
    t_qvr_out          n_data;
    logic [2:0][VW-1:0] s_val;
    logic [2:0]        s_ov;
    logic [QB-1:0]     s_m;

    always_comb begin
        s_m = '0;
        for (int i = 0; i < 3; i++) begin
            s_ov[i]  = i_bus.neg[i] ? (i_bus.quo[i] > LimNeg) : (i_bus.quo[i] > LimPos);
            s_m      = s_ov[i] ? (i_bus.neg[i] ? LimNeg : LimPos) : i_bus.quo[i];
            s_val[i] = i_bus.neg[i] ? VW'(~s_m + QB'(1)) : VW'(s_m);
        end
        if (i_bus.zero) begin
            n_data = '{rot_x: '0, rot_y: '0, rot_z: '0, zero_quat: 1'b1, clipped: 1'b0};
        end else begin
            n_data.rot_x     = s_val[0];
            n_data.rot_y     = s_val[1];
            n_data.rot_z     = s_val[2];
            n_data.zero_quat = 1'b0;
            n_data.clipped   = |s_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

### src/quaternion_vector_rotate_core.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core
// rotates a vector by a non-normalised quaternion, q v q* / |q|^2, saturated
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      i_valid / o_ready   i_data  (t_qvr_in)
// out      output     o_valid / i_ready   o_data  (t_qvr_out)
//
// one transaction per cycle while the output is not stalled
// the restoring divider produces one quotient bit per stage
// each stage holds its own valid bit and takes data when it is empty or
// its successor moves, so bubbles close up behind a stalled output
// synchronous active-low reset clears only the valid bits
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_core import qvr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_qvr_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_qvr_out o_data
);

    // five front stages, QB divide steps, one output register
    localparam int NS = QB + 6;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   s_en;
    t_div_bus      s_bus [QB+1];

    // stage advance: empty, or the next stage advances too
    always_comb begin
        s_en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            s_en[k] = !r_vld[k] || s_en[k+1];
        end
        for (int k = 0; k < NS; k++) begin
            if (s_en[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // products, sums, numerators and rounding offset
    qvr_front u_front (
        .i_clk  (i_clk),
        .i_en   (s_en[4:0]),
        .i_data (i_data),
        .o_bus  (s_bus[0])
    );

    // restoring divide, most significant quotient bit first
    for (genvar j = 0; j < QB; j++) begin : g_div
        qvr_div_step u_step (
            .i_clk (i_clk),
            .i_en  (s_en[5+j]),
            .i_bus (s_bus[j]),
            .o_bus (s_bus[j+1])
        );
    end

    // saturation into the output register
    qvr_sat u_sat (
        .i_clk  (i_clk),
        .i_en   (s_en[NS-1]),
        .i_bus  (s_bus[QB]),
        .o_data (o_data)
    );

    assign o_ready = s_en[0];
    assign o_valid = r_vld[NS-1];

    // input is only refused when the whole pipe is full behind a stalled output
    a_full_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input refused while output is free");

    // an accepted transaction lands in the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction lost at the first stage");

    // a zero quaternion gives a zero vector and no clip
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.zero_quat) |-> (o_data.rot_x == '0 && o_data.rot_y == '0
            && o_data.rot_z == '0 && !o_data.clipped))
        else $error("zero quaternion with non-zero result");

    // a clip puts at least one component on a bound
    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.clipped) |->
            (o_data.rot_x == {1'b0, {(VW-1){1'b1}}} || o_data.rot_x == {1'b1, {(VW-1){1'b0}}}
          || o_data.rot_y == {1'b0, {(VW-1){1'b1}}} || o_data.rot_y == {1'b1, {(VW-1){1'b0}}}
          || o_data.rot_z == {1'b0, {(VW-1){1'b1}}} || o_data.rot_z == {1'b1, {(VW-1){1'b0}}}))
        else $error("clip flagged without a saturated component");

endmodule
